// ===== hw/rtl/i2c_bit_level_master_macros.svh =====
// Assertion macros shared by the I2C bit-level master.
`ifndef I2C_BIT_LEVEL_MASTER_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define I2CBM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define I2CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define I2CBM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define I2CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/i2cbm_pkg.sv =====
`default_nettype none

package i2cbm_pkg;

    // Command codes carried in the operation field.
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_STOP    = 3'd2;
    localparam logic [2:0] OP_WRITE   = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;
    localparam logic [2:0] OP_WAITACK = 3'd5;
    localparam logic [2:0] OP_ACK     = 3'd6;
    localparam logic [2:0] OP_NACK    = 3'd7;

    // Register word index on the configuration port.
    localparam logic CFG_HALF_PERIOD = 1'b0;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd10;

    // Phase at which a byte command finishes.
    localparam logic [4:0] BYTE_LAST_PHASE = 5'd16;

    // Tick as held in the queue between the front and the back.
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] wbyte;
        logic       sda;
        logic       is_cmd;
    } t_tick;

endpackage

`default_nettype wire

// ===== hw/rtl/i2cbm_front.sv =====
`default_nettype none

// Accepts tick words, classifies them and keeps them in a two-entry queue.
module i2cbm_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  wire  [15:0]         i_s_tdata,
    output logic                o_q_valid,
    output i2cbm_pkg::t_tick    o_q_tick,
    input  wire                 i_q_pop
);

    i2cbm_pkg::t_tick r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             w_push;
    i2cbm_pkg::t_tick w_in_tick;

    always_comb begin
        w_in_tick.op     = i_s_tdata[2:0];
        w_in_tick.wbyte  = i_s_tdata[10:3];
        w_in_tick.sda    = i_s_tdata[11];
        w_in_tick.is_cmd = (i_s_tdata[2:0] != i2cbm_pkg::OP_NONE);
    end

    assign o_s_tready = (r_count != 2'd2);
    assign w_push     = i_s_tvalid && o_s_tready;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_tick   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_in_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/i2cbm_back.sv =====
`default_nettype none

// Runs the pin sequencer one queued tick at a time and registers each result word.
module i2cbm_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_valid,
    input  i2cbm_pkg::t_tick    i_q_tick,
    output logic                o_q_pop,
    input  wire  [15:0]         i_half_period,
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output logic [15:0]         o_m_tdata
);

    logic [2:0]  r_cmd,   n_cmd;
    logic [4:0]  r_phase, n_phase;
    logic [15:0] r_tick,  n_tick;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_tx,    n_tx;
    logic        r_ack,   n_ack;
    logic        r_scl,   n_scl;
    logic        r_sda,   n_sda;
    logic        r_busy,  n_busy;
    logic        r_out_valid;
    logic [15:0] r_out_data;

    logic [15:0] w_limit;
    logic [15:0] w_tick_inc;
    logic        w_enter;
    logic        w_last;
    logic        w_done;
    logic        w_rej;

    assign o_q_pop    = i_q_valid && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign w_limit    = (i_half_period == 16'd0) ? 16'd1 : i_half_period;
    assign w_tick_inc = r_tick + 16'd1;

    always_comb begin
        n_cmd   = r_cmd;
        n_phase = r_phase;
        n_tick  = r_tick;
        n_shift = r_shift;
        n_tx    = r_tx;
        n_ack   = r_ack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_busy  = r_busy;
        w_enter = 1'b0;
        w_last  = 1'b0;
        w_done  = 1'b0;
        w_rej   = 1'b0;

        if (r_busy) begin
            w_rej = i_q_tick.is_cmd;
            if (w_tick_inc >= w_limit) begin
                n_tick  = 16'd0;
                n_phase = r_phase + 5'd1;
                w_enter = 1'b1;
            end else begin
                n_tick = w_tick_inc;
            end
        end else if (i_q_tick.is_cmd) begin
            n_cmd   = i_q_tick.op;
            n_phase = 5'd0;
            n_tick  = 16'd0;
            n_tx    = i_q_tick.wbyte;
            n_busy  = 1'b1;
            w_enter = 1'b1;
        end

        // Pin actions of the phase just entered.
        if (w_enter) begin
            unique case (n_cmd)
                i2cbm_pkg::OP_START: begin
                    if (n_phase == 5'd0) begin
                        n_sda = 1'b1;
                        n_scl = 1'b1;
                    end else if (n_phase == 5'd1) begin
                        n_sda = 1'b0;
                    end else begin
                        n_scl  = 1'b0;
                        w_last = 1'b1;
                    end
                end
                i2cbm_pkg::OP_STOP: begin
                    if (n_phase == 5'd0) begin
                        n_scl = 1'b0;
                        n_sda = 1'b0;
                    end else if (n_phase == 5'd1) begin
                        n_scl = 1'b1;
                    end else begin
                        n_sda  = 1'b1;
                        w_last = 1'b1;
                    end
                end
                i2cbm_pkg::OP_WAITACK: begin
                    if (n_phase == 5'd0) begin
                        n_sda = 1'b1;
                    end else if (n_phase == 5'd1) begin
                        n_scl = 1'b1;
                    end else begin
                        n_ack  = ~i_q_tick.sda;
                        n_scl  = 1'b0;
                        w_last = 1'b1;
                    end
                end
                i2cbm_pkg::OP_ACK,
                i2cbm_pkg::OP_NACK: begin
                    if (n_phase == 5'd0) begin
                        n_sda = (n_cmd == i2cbm_pkg::OP_NACK);
                    end else if (n_phase == 5'd1) begin
                        n_scl = 1'b1;
                    end else begin
                        n_scl  = 1'b0;
                        w_last = 1'b1;
                    end
                end
                i2cbm_pkg::OP_WRITE: begin
                    if (n_phase >= i2cbm_pkg::BYTE_LAST_PHASE) begin
                        n_scl  = 1'b0;
                        w_last = 1'b1;
                    end else if (n_phase[0]) begin
                        n_scl = 1'b1;
                    end else begin
                        if (n_phase != 5'd0) begin
                            n_scl = 1'b0;
                        end
                        n_sda = n_tx[7];
                        n_tx  = {n_tx[6:0], 1'b0};
                    end
                end
                i2cbm_pkg::OP_READ: begin
                    if (n_phase >= i2cbm_pkg::BYTE_LAST_PHASE) begin
                        n_scl  = 1'b0;
                        w_last = 1'b1;
                    end else if (n_phase == 5'd0) begin
                        n_sda   = 1'b1;
                        n_shift = 8'd0;
                    end else if (n_phase[0]) begin
                        n_scl   = 1'b1;
                        n_shift = {r_shift[6:0], i_q_tick.sda};
                    end else begin
                        n_scl = 1'b0;
                    end
                end
                default: begin
                    w_last = 1'b1;
                end
            endcase
        end

        // The accepting tick never finishes a command, only later ticks do.
        if (w_last && r_busy) begin
            w_done  = 1'b1;
            n_busy  = 1'b0;
            n_cmd   = i2cbm_pkg::OP_NONE;
            n_phase = 5'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= i2cbm_pkg::OP_NONE;
            r_phase     <= 5'd0;
            r_tick      <= 16'd0;
            r_shift     <= 8'd0;
            r_tx        <= 8'd0;
            r_ack       <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_cmd   <= n_cmd;
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_shift <= n_shift;
                r_tx    <= n_tx;
                r_ack   <= n_ack;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
                r_busy  <= n_busy;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out_data <= {2'b00, w_rej, n_ack, n_shift, w_done, n_busy, n_sda, n_scl};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_bit_level_master.sv =====
`default_nettype none

// Channel   Dir  Handshake             Contents
// s tick    in   i_s_tvalid/o_s_tready one timing tick with an optional command
// m result  out  o_m_tvalid/i_m_tready pin levels and status after that tick
// config    in   psel/penable/pready   half_period register at byte address 0
//
// One tick word is taken every clock when the result side keeps up; each word
// yields one result word in the cycle after it leaves the two-entry tick queue;
// the sequencer update in the back part is registered with that result word.
// Reset is synchronous and active low; afterwards SCL and SDA read released.
// A stalled result side holds the output register, the queue fills and then
// o_s_tready drops; no tick word is ever dropped or repeated.
module i2c_bit_level_master (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Tick stream.
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // [2:0] operation, [10:3] write_byte, [11] sda_line
    // Result stream.
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata,   // [0] scl_level, [1] sda_level, [2] busy_res,
                                     // [3] done_res, [11:4] read_byte, [12] ack_seen,
                                     // [13] cmd_rejected
    // Configuration port.
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    `include "i2c_bit_level_master_macros.svh"

    logic [15:0]      r_half_period;
    logic             w_cfg_write;
    logic             w_q_valid;
    logic             w_q_pop;
    i2cbm_pkg::t_tick w_q_tick;

    // The register file is one word; bit 2 of the address selects the word.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign prdata      = (paddr[2] == i2cbm_pkg::CFG_HALF_PERIOD)
                         ? {16'd0, r_half_period} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= i2cbm_pkg::HALF_PERIOD_RESET;
        end else if (w_cfg_write && (paddr[2] == i2cbm_pkg::CFG_HALF_PERIOD)) begin
            r_half_period <= pwdata[15:0];
        end
    end

    // The front takes tick words and queues them with their command class.
    i2cbm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_q_valid  (w_q_valid),
        .o_q_tick   (w_q_tick),
        .i_q_pop    (w_q_pop)
    );

    // The back runs the phase sequencer and owns the result register.
    i2cbm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_tick      (w_q_tick),
        .o_q_pop       (w_q_pop),
        .i_half_period (r_half_period),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)
    );

    // The sequencer only advances when the result register can take its word.
    `I2CBM_ASSERT_SAME(a_pop_needs_room, i_clk, i_rst_n, w_q_pop, (!o_m_tvalid || i_m_tready))
    // A finishing tick always reports the block as no longer busy.
    `I2CBM_ASSERT_SAME(a_done_not_busy, i_clk, i_rst_n, (o_m_tvalid && o_m_tdata[3]),
        !o_m_tdata[2])
    // A register write lands in the half period on the next cycle.
    `I2CBM_ASSERT_NEXT(a_cfg_write, i_clk, i_rst_n,
        (w_cfg_write && (paddr[2] == i2cbm_pkg::CFG_HALF_PERIOD)),
        (r_half_period == $past(pwdata[15:0])))

endmodule

`default_nettype wire
